>>> hw/rtl/pett_pkg.sv
package pett_pkg;

    // Default sizing
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int TICK_WIDTH_DEF   = 32;

    // Channel limit after reset
    localparam logic [4:0] LIMIT_RESET = 5'd16;

    // Command codes
    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_CHECK   = 3'd1,
        CMD_SET_EN  = 3'd2,
        CMD_SET_DUR = 3'd3,
        CMD_QUERY   = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    // Kind of result word the datapath builds
    typedef enum logic [2:0] {
        RES_ADD,
        RES_FULL,
        RES_RANGE,
        RES_FIRED,
        RES_SUMMARY,
        RES_ACCESS,
        RES_EMPTY
    } res_kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_SUMMARY,
        ST_RMW
    } state_t;

    // Request word
    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] now_tick;
        logic [3:0]  channel_index;
        logic        enable_bit;
        logic [31:0] period_ticks;
        logic        restamp;
    } req_t;

    // Response word
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_index;
        logic        flag;
        logic [31:0] old_period;
        logic        last;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      add_commit;
        logic      rmw_read;
        logic      rmw_commit;
        logic      scan_start;
        logic      scan_step;
        logic      emit;
        res_kind_t kind;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic table_full;
        logic index_bad;
        logic table_empty;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

>>> hw/rtl/pett_ram.sv
module pett_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/pett_ctrl.sv
module pett_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pett_pkg::ctrl_stat_t stat,
    output pett_pkg::ctrl_cmd_t  cmd
);

    pett_pkg::state_t state_reg;
    pett_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pett_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pett_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = pett_pkg::ST_DISPATCH;
                end
            end
            pett_pkg::ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    pett_pkg::CMD_CHECK:
                    begin
                        state_next = stat.table_empty ? pett_pkg::ST_SUMMARY
                                                      : pett_pkg::ST_SCAN;
                    end
                    pett_pkg::CMD_SET_EN, pett_pkg::CMD_SET_DUR, pett_pkg::CMD_QUERY:
                    begin
                        if (!stat.index_bad)
                        begin
                            state_next = pett_pkg::ST_RMW;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = pett_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            state_next = pett_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            pett_pkg::ST_SCAN:
            begin
                if ((!stat.scan_hit || stat.out_free) && stat.scan_last)
                begin
                    state_next = pett_pkg::ST_SUMMARY;
                end
            end
            pett_pkg::ST_SUMMARY, pett_pkg::ST_RMW:
            begin
                if (stat.out_free)
                begin
                    state_next = pett_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pett_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready      = 1'b0;
        cmd.load       = 1'b0;
        cmd.add_commit = 1'b0;
        cmd.rmw_read   = 1'b0;
        cmd.rmw_commit = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.emit       = 1'b0;
        cmd.kind       = pett_pkg::RES_EMPTY;
        unique case (state_reg)
            pett_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            pett_pkg::ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    pett_pkg::CMD_ADD:
                    begin
                        cmd.emit       = stat.out_free;
                        cmd.add_commit = stat.out_free && !stat.table_full;
                        cmd.kind       = stat.table_full ? pett_pkg::RES_FULL
                                                         : pett_pkg::RES_ADD;
                    end
                    pett_pkg::CMD_CHECK:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    pett_pkg::CMD_SET_EN, pett_pkg::CMD_SET_DUR, pett_pkg::CMD_QUERY:
                    begin
                        cmd.rmw_read = !stat.index_bad;
                        cmd.emit     = stat.index_bad && stat.out_free;
                        cmd.kind     = pett_pkg::RES_RANGE;
                    end
                    default:
                    begin
                        cmd.emit = stat.out_free;
                        cmd.kind = pett_pkg::RES_EMPTY;
                    end
                endcase
            end
            pett_pkg::ST_SCAN:
            begin
                cmd.scan_step = !stat.scan_hit || stat.out_free;
                cmd.emit      = stat.scan_hit && stat.out_free;
                cmd.kind      = pett_pkg::RES_FIRED;
            end
            pett_pkg::ST_SUMMARY:
            begin
                cmd.emit = stat.out_free;
                cmd.kind = pett_pkg::RES_SUMMARY;
            end
            pett_pkg::ST_RMW:
            begin
                cmd.emit       = stat.out_free;
                cmd.rmw_commit = stat.out_free;
                cmd.kind       = pett_pkg::RES_ACCESS;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/pett_dpath.sv
module pett_dpath #(
    parameter int MAX_CHANNELS = pett_pkg::MAX_CHANNELS_DEF,
    parameter int TICK_WIDTH   = pett_pkg::TICK_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 limit_wr_en,
    input  logic [4:0]           limit_wr_data,
    input  pett_pkg::req_t       req,
    input  pett_pkg::ctrl_cmd_t  cmd,
    output pett_pkg::ctrl_stat_t stat,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output pett_pkg::rsp_t       rsp
);

    localparam int AW = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int TW = TICK_WIDTH;
    localparam int EW = 1 + 2 * TW;

    // Control registers
    logic [4:0]     limit_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [AW-1:0]  scan_idx_reg;
    logic [AW-1:0]  scan_idx_next;
    logic           fired_reg;
    logic           fired_next;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;

    // Captured request and response payload
    pett_pkg::cmd_t cmd_reg;
    logic [TW-1:0]  now_reg;
    logic [3:0]     idx_reg;
    logic           en_reg;
    logic [TW-1:0]  per_reg;
    logic           rs_reg;
    pett_pkg::rsp_t rsp_reg;
    pett_pkg::rsp_t rsp_next;

    // Table port
    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    logic [EW-1:0]  ram_wr_data;
    logic           ram_rd_en;
    logic [AW-1:0]  ram_rd_addr;
    logic [EW-1:0]  ram_rd_data;

    // Fields of the entry just read
    logic           rd_en_bit;
    logic [TW-1:0]  rd_per;
    logic [TW-1:0]  rd_last;
    logic [TW-1:0]  due;
    logic [TW-1:0]  rmw_last;
    logic           out_free;

    assign rd_en_bit = ram_rd_data[EW-1];
    assign rd_per    = ram_rd_data[2*TW-1:TW];
    assign rd_last   = ram_rd_data[TW-1:0];
    assign due       = rd_per + rd_last;
    assign rmw_last  = rs_reg ? now_reg : rd_last;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Status to controller
    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.table_full  = (int'(count_reg) >= int'(limit_reg))
                           || (int'(count_reg) >= MAX_CHANNELS);
        stat.index_bad   = (int'(idx_reg) >= int'(count_reg))
                           || (int'(idx_reg) >= MAX_CHANNELS);
        stat.table_empty = (count_reg == '0);
        stat.scan_hit    = rd_en_bit && (due <= now_reg);
        stat.scan_last   = (int'(scan_idx_reg) + 1) >= int'(count_reg);
        stat.out_free    = out_free;
    end

    // Table write and read selection
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = scan_idx_reg;
        ram_wr_data = {rd_en_bit, rd_per, now_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(idx_reg);
        priority if (cmd.add_commit)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_reg[AW-1:0];
            ram_wr_data = {en_reg, per_reg, now_reg};
        end
        else if (cmd.rmw_commit)
        begin
            ram_wr_en   = (cmd_reg != pett_pkg::CMD_QUERY);
            ram_wr_addr = AW'(idx_reg);
            if (cmd_reg == pett_pkg::CMD_SET_EN)
            begin
                ram_wr_data = {en_reg, rd_per, rmw_last};
            end
            else
            begin
                ram_wr_data = {rd_en_bit, per_reg, rmw_last};
            end
        end
        else if (cmd.scan_step)
        begin
            // restamp a firing channel
            ram_wr_en = stat.scan_hit;
        end

        priority if (cmd.rmw_read)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(idx_reg);
        end
        else if (cmd.scan_start)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
        end
        else if (cmd.scan_step)
        begin
            ram_rd_en   = !stat.scan_last;
            ram_rd_addr = scan_idx_reg + AW'(1);
        end
    end

    pett_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CHANNELS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Count, scan and fired tracking
    always_comb
    begin
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        fired_next    = fired_reg;
        if (cmd.add_commit)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
            fired_next    = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + AW'(1);
            fired_next    = fired_reg || stat.scan_hit;
        end
    end

    // Result word
    always_comb
    begin
        rsp_next              = '0;
        rsp_next.last         = 1'b1;
        rsp_next.status       = pett_pkg::STAT_OK;
        unique case (cmd.kind)
            pett_pkg::RES_ADD:
            begin
                rsp_next.result_index = 4'(count_reg);
            end
            pett_pkg::RES_FULL:
            begin
                rsp_next.status = pett_pkg::STAT_FULL;
            end
            pett_pkg::RES_RANGE:
            begin
                rsp_next.status = pett_pkg::STAT_RANGE;
            end
            pett_pkg::RES_FIRED:
            begin
                rsp_next.result_index = 4'(scan_idx_reg);
                rsp_next.last         = 1'b0;
            end
            pett_pkg::RES_SUMMARY:
            begin
                rsp_next.flag = fired_reg;
            end
            pett_pkg::RES_ACCESS:
            begin
                if (cmd_reg == pett_pkg::CMD_SET_DUR)
                begin
                    rsp_next.old_period = 32'(rd_per);
                end
                else
                begin
                    rsp_next.flag = rd_en_bit;
                end
            end
            default:
            begin
                rsp_next.last = 1'b1;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // Control registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= pett_pkg::LIMIT_RESET;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            fired_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (limit_wr_en)
            begin
                limit_reg <= limit_wr_data;
            end
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            fired_reg     <= fired_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= pett_pkg::cmd_t'(req.command);
            now_reg <= TW'(req.now_tick);
            idx_reg <= req.channel_index;
            en_reg  <= req.enable_bit;
            per_reg <= TW'(req.period_ticks);
            rs_reg  <= req.restamp;
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/periodic_event_timer_table.sv
// Periodic event timer table: up to MAX_CHANNELS timer channels, each with an
// enable bit, a period and its last firing tick, kept in one RAM. One request
// word is taken at a time. A check scans the table, reading one channel per
// cycle through the single RAM read port unless a firing channel waits on a
// stalled response side, emits one word per firing channel and ends with a
// summary word. The channel limit can be written at any idle time and resets
// to sixteen.
module periodic_event_timer_table #(
    parameter int MAX_CHANNELS = pett_pkg::MAX_CHANNELS_DEF,
    parameter int TICK_WIDTH   = pett_pkg::TICK_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           limit_wr_en,
    input  logic [4:0]     limit_wr_data,
    input  logic           req_valid,
    output logic           req_ready,
    input  pett_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pett_pkg::rsp_t rsp
);

    pett_pkg::ctrl_cmd_t  cmd;
    pett_pkg::ctrl_stat_t stat;

    // Sequencer
    pett_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, counters and response register
    pett_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .TICK_WIDTH   (TICK_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .limit_wr_en   (limit_wr_en),
        .limit_wr_data (limit_wr_data),
        .req           (req),
        .cmd           (cmd),
        .stat          (stat),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;

    import pett_pkg::*;

    localparam int MAX_CH = MAX_CHANNELS_DEF;
    localparam int CLK_HALF = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 25;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_PRINTED = 40;

    // command codes the block answers with an empty word
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       limit_wr_en = 1'b0;
    logic [4:0] limit_wr_data = '0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;

    periodic_event_timer_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .limit_wr_en   (limit_wr_en),
        .limit_wr_data (limit_wr_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp)
    );

    // shadow copy of the timer table
    logic [4:0]  tbl_limit = LIMIT_RESET;
    int unsigned tbl_count = 0;
    logic        tbl_en[MAX_CH];
    logic [31:0] tbl_period[MAX_CH];
    logic [31:0] tbl_last_fired[MAX_CH];

    rsp_t        timer_words_due[$];
    int          err_count = 0;
    int          send_idle_pct = 20;
    int          recv_idle_pct = 20;
    logic [31:0] tick_base = 32'd1000;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTED)
            $display("ERROR @%0t: %s got %0h want %0h", $time, what, got, want);
        err_count++;
    endtask

    // work out the words one request word causes, updating the shadow table
    task automatic predict_timer_words(input req_t r);
        int unsigned lim;
        int          i;
        logic [31:0] due;
        logic        any_fired;
        rsp_t        w;
        rsp_t        fired_w;
        lim = (tbl_limit < MAX_CH) ? int'(tbl_limit) : MAX_CH;
        w = '0;
        w.last = 1'b1;
        case (r.command)
            CMD_ADD:
            begin
                if (tbl_count >= lim)
                    w.status = STAT_FULL;
                else
                begin
                    tbl_en[tbl_count] = r.enable_bit;
                    tbl_period[tbl_count] = r.period_ticks;
                    tbl_last_fired[tbl_count] = r.now_tick;
                    w.result_index = tbl_count[3:0];
                    tbl_count++;
                end
            end
            CMD_CHECK:
            begin
                any_fired = 1'b0;
                for (i = 0; i < tbl_count; i++)
                begin
                    due = tbl_period[i] + tbl_last_fired[i];
                    if (tbl_en[i] && due <= r.now_tick)
                    begin
                        any_fired = 1'b1;
                        tbl_last_fired[i] = r.now_tick;
                        fired_w = '0;
                        fired_w.result_index = i[3:0];
                        timer_words_due.push_back(fired_w);
                    end
                end
                w.flag = any_fired;
            end
            CMD_SET_EN, CMD_SET_DUR, CMD_QUERY:
            begin
                if (r.channel_index >= tbl_count)
                    w.status = STAT_RANGE;
                else if (r.command == CMD_QUERY)
                    w.flag = tbl_en[r.channel_index];
                else if (r.command == CMD_SET_EN)
                begin
                    w.flag = tbl_en[r.channel_index];
                    tbl_en[r.channel_index] = r.enable_bit;
                    if (r.restamp)
                        tbl_last_fired[r.channel_index] = r.now_tick;
                end
                else
                begin
                    w.old_period = tbl_period[r.channel_index];
                    tbl_period[r.channel_index] = r.period_ticks;
                    if (r.restamp)
                        tbl_last_fired[r.channel_index] = r.now_tick;
                end
            end
            default:
            begin
            end
        endcase
        timer_words_due.push_back(w);
    endtask

    // predict on each accepted request, compare each accepted response
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && req_valid && req_ready)
            predict_timer_words(req);
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (timer_words_due.size() == 0)
                report_mismatch("response word with none expected, status",
                                32'(rsp.status), 32'd0);
            else
            begin
                want = timer_words_due.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.result_index !== want.result_index)
                    report_mismatch("result_index", 32'(rsp.result_index),
                                    32'(want.result_index));
                if (rsp.flag !== want.flag)
                    report_mismatch("flag", 32'(rsp.flag), 32'(want.flag));
                if (rsp.old_period !== want.old_period)
                    report_mismatch("old_period", rsp.old_period, want.old_period);
                if (rsp.last !== want.last)
                    report_mismatch("last", 32'(rsp.last), 32'(want.last));
            end
        end
    end

    // response side back-pressure
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic req_t mk_req(input logic [2:0] c, input logic [31:0] now,
                                    input logic [3:0] idx, input logic en,
                                    input logic [31:0] per, input logic rs);
        req_t r;
        r.command = c;
        r.now_tick = now;
        r.channel_index = idx;
        r.enable_bit = en;
        r.period_ticks = per;
        r.restamp = rs;
        return r;
    endfunction

    // drive one request word and wait until it is taken
    task automatic send_word(input req_t r);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // stop sending and let every expected word come back
    task automatic wait_for_all_words();
        @(negedge clk);
        req_valid <= 1'b0;
        while (timer_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_channel_limit(input logic [4:0] value);
        wait_for_all_words();
        @(negedge clk);
        limit_wr_en <= 1'b1;
        limit_wr_data <= value;
        @(negedge clk);
        limit_wr_en <= 1'b0;
        tbl_limit = value;
    endtask

    // mostly well-formed traffic on a moving tick, some bad indices and codes
    task automatic send_random_word();
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if ($urandom_range(15) == 0)
            tick_base = $urandom();
        else
            tick_base = tick_base + $urandom_range(0, 40);
        r.now_tick = tick_base;
        pick = $urandom_range(9);
        if (pick < 8)
            r.period_ticks = $urandom_range(1, 60);
        else if (pick == 8)
            r.period_ticks = '0;
        else
            r.period_ticks = $urandom();
        r.enable_bit = ($urandom_range(99) < 80);
        r.restamp = 1'($urandom_range(1));
        if (tbl_count > 0 && $urandom_range(99) < 85)
            r.channel_index = 4'($urandom_range(tbl_count - 1));
        else
            r.channel_index = 4'($urandom_range(MAX_CH - 1));
        pick = $urandom_range(99);
        if (pick < 35)
            r.command = CMD_CHECK;
        else if (pick < 47)
            r.command = CMD_ADD;
        else if (pick < 62)
            r.command = CMD_SET_EN;
        else if (pick < 77)
            r.command = CMD_SET_DUR;
        else if (pick < 90)
            r.command = CMD_QUERY;
        else
            r.command = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        send_word(r);
    endtask

    // a check, a query and both sets on an empty table, and the reserved codes
    task automatic test_empty_table();
        int c;
        send_word(mk_req(CMD_CHECK, '0, '0, 1'b0, '0, 1'b0));
        send_word(mk_req(CMD_QUERY, 32'd5, 4'd0, 1'b1, '1, 1'b1));
        send_word(mk_req(CMD_SET_EN, 32'd6, 4'd15, 1'b1, '0, 1'b1));
        send_word(mk_req(CMD_SET_DUR, 32'd7, 4'd0, 1'b0, '1, 1'b0));
        for (c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
            send_word(mk_req(3'(c), '1, '1, 1'b1, '1, 1'b1));
    endtask

    // table full at limit 1 and limit 0, then a wrapping period
    task automatic test_channel_limit();
        write_channel_limit(5'd1);
        send_word(mk_req(CMD_ADD, 32'd100, '0, 1'b1, '0, 1'b0));
        send_word(mk_req(CMD_ADD, 32'd101, '0, 1'b1, 32'd3, 1'b0));
        write_channel_limit(5'd0);
        send_word(mk_req(CMD_ADD, 32'd102, '0, 1'b1, 32'd3, 1'b0));
        write_channel_limit(5'd4);
        send_word(mk_req(CMD_ADD, 32'd200, '0, 1'b1, '1, 1'b0));
        send_word(mk_req(CMD_ADD, 32'd200, '0, 1'b0, 32'd10, 1'b1));
        send_word(mk_req(CMD_CHECK, 32'd200, '0, 1'b0, '0, 1'b0));
    endtask

    // set, query and restamp, with ticks at both ends of the range
    task automatic test_channel_access();
        send_word(mk_req(CMD_SET_EN, 32'd300, 4'd2, 1'b1, '0, 1'b1));
        send_word(mk_req(CMD_QUERY, 32'd300, 4'd2, 1'b0, '0, 1'b0));
        send_word(mk_req(CMD_SET_DUR, 32'd301, 4'd2, 1'b0, 32'd5, 1'b0));
        send_word(mk_req(CMD_CHECK, 32'd304, '0, 1'b0, '0, 1'b0));
        send_word(mk_req(CMD_SET_DUR, 32'hFFFF_FFF0, 4'd1, 1'b0, 32'h8000_0000, 1'b1));
        send_word(mk_req(CMD_CHECK, '1, '0, 1'b0, '0, 1'b0));
        send_word(mk_req(CMD_QUERY, '1, 4'd3, 1'b1, '1, 1'b1));
        send_word(mk_req(CMD_SET_EN, '0, 4'd1, 1'b0, '0, 1'b0));
        send_word(mk_req(CMD_CHECK, '0, '0, 1'b0, '0, 1'b0));
    endtask

    // oversized limit lets the table fill to its hard size
    task automatic test_random_mix();
        int n;
        write_channel_limit(5'd31);
        for (n = 0; n < 120; n++)
        begin
            // hold off once until the block has answered everything
            if (n == 60)
                wait_for_all_words();
            send_random_word();
        end
    endtask

    task automatic test_back_to_back();
        int n;
        write_channel_limit(LIMIT_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (n = 0; n < 60; n++)
            send_random_word();
        send_idle_pct = 20;
        recv_idle_pct = 20;
    endtask

    // limit dropped under the channel count: adds refused, table kept
    task automatic test_limit_below_count();
        int n;
        write_channel_limit(5'($urandom_range(1, 15)));
        for (n = 0; n < 40; n++)
            send_random_word();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_channel_limit();
        test_channel_access();
        test_random_mix();
        test_back_to_back();
        test_limit_below_count();
        wait_for_all_words();
        repeat (END_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> periodic_event_timer_table.f
hw/rtl/pett_pkg.sv
hw/rtl/pett_ram.sv
hw/rtl/pett_ctrl.sv
hw/rtl/pett_dpath.sv
hw/rtl/periodic_event_timer_table.sv
tb/tb_top.sv
